>>> rtl/core/tmprof_pkg.sv
`default_nettype none
package tmprof_pkg;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_VA,
    ST_MUL_AT,
    ST_MUL_ATT,
    ST_DECIDE,
    ST_DIV_DA,
    ST_SQRT,
    ST_MUL_PK,
    ST_MUL_PKT,
    ST_DIV_REM,
    ST_PLAN_END,
    ST_SAMP,
    ST_MUL_A,
    ST_MUL_AA,
    ST_MUL_PEAK,
    ST_SAMP_END,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RGN_ACCEL,
    RGN_CRUISE,
    RGN_DECEL
  } region_t;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_NO_PLAN    = 2'd1;
  localparam logic [1:0] STS_ZERO_LIMIT = 2'd2;

  localparam logic CMD_PLAN   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] CFG_DIST  = 2'd0;
  localparam logic [1:0] CFG_VEL   = 2'd1;
  localparam logic [1:0] CFG_ACCEL = 2'd2;

endpackage
`default_nettype wire

>>> rtl/core/trapezoid_motion_profile_core.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  command, sample_time
// out_      output     out_valid/out_stall position, velocity, total_time, status
// cfg_      input      cfg_we             cfg_index, cfg_wdata
//
// One item at a time through a shared bit-serial unit (multiply, divide, square root).
// Plan: div + 2 mul, then one div or, for a triangle, div + sqrt + 2 mul.
// Sample: 1 to 3 multiplies. Errors go straight to the output state. Synchronous
// active-low reset; a finished result waits in the output register while the next
// transaction is accepted.
module trapezoid_motion_profile_core #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [WORD_BITS-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [WORD_BITS-1:0] in_sample_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WORD_BITS-1:0]      out_position,
  output logic [WORD_BITS-1:0]      out_velocity,
  output logic [WORD_BITS-1:0]      out_total_time,
  output logic [1:0]                out_status
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  tmprof_pkg::state_t    state_r, state_nxt;
  tmprof_pkg::region_t   region_r;
  tmprof_pkg::alu_req_t  alu_req;
  tmprof_pkg::alu_stat_t alu_stat;
  logic [W-1:0] alu_res, alu_x, alu_y;

  logic [W-1:0] dist_cfg_r, vel_cfg_r, acc_cfg_r;
  logic [W-1:0] ramp_time_r, cruise_end_r, plan_total_time_r;
  logic [W-1:0] peak_velocity_r, ramp_distance_r, plan_dist_r, plan_acc_r;
  logic         plan_valid_r;
  logic [W-1:0] t_r, teff_r, tmp_r, half_r, m_r;
  logic [W-1:0] res_pos_r, res_vel_r, res_tot_r;
  logic [1:0]   res_sts_r;
  logic         out_valid_r;
  logic [W-1:0] out_position_r, out_velocity_r, out_total_time_r;
  logic [1:0]   out_status_r;

  logic         accept, out_load, zero_limit, is_tri;
  logic [W-1:0] dist_floor, tot_2tr, rem_dist, decel_base, pos_final, vel_final;
  logic [W:0]   sum_2tr, sum_tot, sum_r1, pos_raw;
  logic [W+1:0] s_r2;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = state_r != tmprof_pkg::ST_IDLE;
  assign out_load   = (state_r == tmprof_pkg::ST_OUT) && (!out_valid_r || !out_stall);
  assign zero_limit = (vel_cfg_r == '0) || (acc_cfg_r == '0);
  assign dist_floor = (dist_cfg_r == '0) ? W'(1) : dist_cfg_r;
  assign is_tri     = {ramp_distance_r, 1'b0} >= {1'b0, plan_dist_r};
  assign rem_dist   = plan_dist_r - {ramp_distance_r[W-2:0], 1'b0};

  assign sum_2tr = {1'b0, ramp_time_r} + {1'b0, ramp_time_r};
  assign tot_2tr = sum_2tr[W] ? '1 : sum_2tr[W-1:0];
  assign sum_tot = {1'b0, tot_2tr} + {1'b0, alu_res};

  // sample result assembly
  assign decel_base = (plan_dist_r > ramp_distance_r) ? plan_dist_r - ramp_distance_r : '0;
  assign sum_r1 = {1'b0, ramp_distance_r} + {1'b0, m_r};
  assign s_r2   = {2'b0, decel_base} + {2'b0, m_r} - {2'b0, half_r};

  always_comb begin
    case (region_r)
      tmprof_pkg::RGN_ACCEL: begin
        pos_raw   = {1'b0, half_r};
        vel_final = tmp_r;
      end
      tmprof_pkg::RGN_CRUISE: begin
        pos_raw   = sum_r1[W] ? {1'b0, {W{1'b1}}} : sum_r1;
        vel_final = peak_velocity_r;
      end
      default: begin
        pos_raw   = s_r2[W+1] ? '0 : s_r2[W:0];
        vel_final = (peak_velocity_r > tmp_r) ? peak_velocity_r - tmp_r : '0;
      end
    endcase
    pos_final = (pos_raw > {1'b0, plan_dist_r}) ? plan_dist_r : pos_raw[W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmprof_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_command == tmprof_pkg::CMD_PLAN) begin
            state_nxt = zero_limit ? tmprof_pkg::ST_OUT : tmprof_pkg::ST_DIV_VA;
          end else begin
            state_nxt = plan_valid_r ? tmprof_pkg::ST_SAMP : tmprof_pkg::ST_OUT;
          end
        end
      end
      tmprof_pkg::ST_DIV_VA:  if (alu_stat.done) state_nxt = tmprof_pkg::ST_MUL_AT;
      tmprof_pkg::ST_MUL_AT:  if (alu_stat.done) state_nxt = tmprof_pkg::ST_MUL_ATT;
      tmprof_pkg::ST_MUL_ATT: if (alu_stat.done) state_nxt = tmprof_pkg::ST_DECIDE;
      tmprof_pkg::ST_DECIDE:  state_nxt = is_tri ? tmprof_pkg::ST_DIV_DA : tmprof_pkg::ST_DIV_REM;
      tmprof_pkg::ST_DIV_DA:  if (alu_stat.done) state_nxt = tmprof_pkg::ST_SQRT;
      tmprof_pkg::ST_SQRT:    if (alu_stat.done) state_nxt = tmprof_pkg::ST_MUL_PK;
      tmprof_pkg::ST_MUL_PK:  if (alu_stat.done) state_nxt = tmprof_pkg::ST_MUL_PKT;
      tmprof_pkg::ST_MUL_PKT: if (alu_stat.done) state_nxt = tmprof_pkg::ST_PLAN_END;
      tmprof_pkg::ST_DIV_REM: if (alu_stat.done) state_nxt = tmprof_pkg::ST_PLAN_END;
      tmprof_pkg::ST_PLAN_END: state_nxt = tmprof_pkg::ST_OUT;
      tmprof_pkg::ST_SAMP: begin
        if (t_r <= ramp_time_r)       state_nxt = tmprof_pkg::ST_MUL_A;
        else if (t_r <= cruise_end_r) state_nxt = tmprof_pkg::ST_MUL_PEAK;
        else                          state_nxt = tmprof_pkg::ST_MUL_A;
      end
      tmprof_pkg::ST_MUL_A:   if (alu_stat.done) state_nxt = tmprof_pkg::ST_MUL_AA;
      tmprof_pkg::ST_MUL_AA: begin
        if (alu_stat.done) begin
          state_nxt = (region_r == tmprof_pkg::RGN_ACCEL) ? tmprof_pkg::ST_SAMP_END
                                                          : tmprof_pkg::ST_MUL_PEAK;
        end
      end
      tmprof_pkg::ST_MUL_PEAK: if (alu_stat.done) state_nxt = tmprof_pkg::ST_SAMP_END;
      tmprof_pkg::ST_SAMP_END: state_nxt = tmprof_pkg::ST_OUT;
      tmprof_pkg::ST_OUT:      if (out_load) state_nxt = tmprof_pkg::ST_IDLE;
      default:                 state_nxt = tmprof_pkg::ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = tmprof_pkg::ALU_MUL;
    alu_x         = plan_acc_r;
    alu_y         = ramp_time_r;
    unique case (state_r)
      tmprof_pkg::ST_DIV_VA: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmprof_pkg::ALU_DIV;
        alu_x         = vel_cfg_r;
        alu_y         = plan_acc_r;
      end
      tmprof_pkg::ST_MUL_AT, tmprof_pkg::ST_MUL_PK: begin
        alu_req.start = 1'b1;
      end
      tmprof_pkg::ST_MUL_ATT: begin
        alu_req.start = 1'b1;
        alu_x         = tmp_r;
      end
      tmprof_pkg::ST_DIV_DA: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmprof_pkg::ALU_DIV;
        alu_x         = plan_dist_r;
        alu_y         = plan_acc_r;
      end
      tmprof_pkg::ST_SQRT: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmprof_pkg::ALU_SQRT;
        alu_x         = tmp_r;
      end
      tmprof_pkg::ST_MUL_PKT: begin
        alu_req.start = 1'b1;
        alu_x         = peak_velocity_r;
      end
      tmprof_pkg::ST_DIV_REM: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmprof_pkg::ALU_DIV;
        alu_x         = rem_dist;
        alu_y         = vel_cfg_r;
      end
      tmprof_pkg::ST_MUL_A: begin
        alu_req.start = 1'b1;
        alu_y         = teff_r;
      end
      tmprof_pkg::ST_MUL_AA: begin
        alu_req.start = 1'b1;
        alu_x         = tmp_r;
        alu_y         = teff_r;
      end
      tmprof_pkg::ST_MUL_PEAK: begin
        alu_req.start = 1'b1;
        alu_x         = peak_velocity_r;
        alu_y         = teff_r;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
    // hold off while the unit is busy or a result is being handed back
    alu_req.start = alu_req.start && !alu_stat.busy && !alu_stat.done;
  end

  tmprof_alu #(
    .W (W),
    .F (F)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opx    (alu_x),
    .opy    (alu_y),
    .stat   (alu_stat),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= tmprof_pkg::ST_IDLE;
      dist_cfg_r        <= W'(1) << F;
      vel_cfg_r         <= W'(1) << F;
      acc_cfg_r         <= W'(1) << F;
      plan_valid_r      <= 1'b0;
      ramp_time_r       <= '0;
      cruise_end_r      <= '0;
      plan_total_time_r <= '0;
      peak_velocity_r   <= '0;
      ramp_distance_r   <= '0;
      plan_dist_r       <= '0;
      plan_acc_r        <= '0;
      region_r          <= tmprof_pkg::RGN_ACCEL;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tmprof_pkg::CFG_DIST:  dist_cfg_r <= cfg_wdata;
          tmprof_pkg::CFG_VEL:   vel_cfg_r  <= cfg_wdata;
          tmprof_pkg::CFG_ACCEL: acc_cfg_r  <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        tmprof_pkg::ST_IDLE: begin
          if (accept) begin
            res_pos_r <= '0;
            res_vel_r <= '0;
            res_tot_r <= '0;
            t_r       <= in_sample_time;
            if (in_command == tmprof_pkg::CMD_PLAN) begin
              res_sts_r <= zero_limit ? tmprof_pkg::STS_ZERO_LIMIT : tmprof_pkg::STS_OK;
              if (zero_limit) begin
                plan_valid_r <= 1'b0;
              end else begin
                plan_dist_r <= dist_floor;
                plan_acc_r  <= acc_cfg_r;
              end
            end else begin
              res_sts_r <= plan_valid_r ? tmprof_pkg::STS_OK : tmprof_pkg::STS_NO_PLAN;
            end
          end
        end
        tmprof_pkg::ST_DIV_VA:  if (alu_stat.done) ramp_time_r <= alu_res;
        tmprof_pkg::ST_MUL_AT:  if (alu_stat.done) tmp_r <= alu_res;
        tmprof_pkg::ST_MUL_ATT: if (alu_stat.done) ramp_distance_r <= alu_res >> 1;
        tmprof_pkg::ST_DIV_DA:  if (alu_stat.done) tmp_r <= alu_res;
        tmprof_pkg::ST_SQRT:    if (alu_stat.done) ramp_time_r <= alu_res;
        tmprof_pkg::ST_MUL_PK:  if (alu_stat.done) peak_velocity_r <= alu_res;
        tmprof_pkg::ST_MUL_PKT: begin
          if (alu_stat.done) begin
            ramp_distance_r   <= alu_res >> 1;
            plan_total_time_r <= tot_2tr;
          end
        end
        tmprof_pkg::ST_DIV_REM: begin
          if (alu_stat.done) begin
            peak_velocity_r   <= vel_cfg_r;
            plan_total_time_r <= sum_tot[W] ? '1 : sum_tot[W-1:0];
          end
        end
        tmprof_pkg::ST_PLAN_END: begin
          cruise_end_r <= (plan_total_time_r >= ramp_time_r) ?
                          plan_total_time_r - ramp_time_r : '0;
          plan_valid_r <= 1'b1;
          res_tot_r    <= plan_total_time_r;
        end
        tmprof_pkg::ST_SAMP: begin
          if (t_r <= ramp_time_r) begin
            region_r <= tmprof_pkg::RGN_ACCEL;
            teff_r   <= t_r;
          end else if (t_r <= cruise_end_r) begin
            region_r <= tmprof_pkg::RGN_CRUISE;
            teff_r   <= t_r - ramp_time_r;
          end else begin
            region_r <= tmprof_pkg::RGN_DECEL;
            teff_r   <= t_r - cruise_end_r;
          end
        end
        tmprof_pkg::ST_MUL_A:    if (alu_stat.done) tmp_r <= alu_res;
        tmprof_pkg::ST_MUL_AA:   if (alu_stat.done) half_r <= alu_res >> 1;
        tmprof_pkg::ST_MUL_PEAK: if (alu_stat.done) m_r <= alu_res;
        tmprof_pkg::ST_SAMP_END: begin
          res_pos_r <= pos_final;
          res_vel_r <= vel_final;
          res_tot_r <= plan_total_time_r;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position_r   <= res_pos_r;
      out_velocity_r   <= res_vel_r;
      out_total_time_r <= res_tot_r;
      out_status_r     <= res_sts_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_velocity   = out_velocity_r;
  assign out_total_time = out_total_time_r;
  assign out_status     = out_status_r;

  a_alu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_stat.busy)
    else $error("unit started while busy");

  a_plan_order: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid_r && state_r == tmprof_pkg::ST_IDLE |-> cruise_end_r <= plan_total_time_r)
    else $error("cruise end beyond total time");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != tmprof_pkg::STS_OK
      |-> out_position_r == '0 && out_velocity_r == '0)
    else $error("error transaction carries motion data");

  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= tmprof_pkg::STS_ZERO_LIMIT)
    else $error("undefined status code");

endmodule
`default_nettype wire

>>> rtl/core/tmprof_alu.sv
`default_nettype none
// Bit-serial fixed point unit: multiply (one multiplier bit per cycle),
// restoring divide (one quotient bit per cycle), square root (one root bit per cycle).
module tmprof_alu #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmprof_pkg::alu_req_t req,
  input  wire logic [W-1:0]      opx,
  input  wire logic [W-1:0]      opy,
  output tmprof_pkg::alu_stat_t  stat,
  output logic      [W-1:0]      result
);

  localparam int N  = W + F;
  localparam int CW = $clog2(N);

  tmprof_pkg::alu_op_t op_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [W-1:0]  hi_r;
  logic [W-1:0]  lo_r;
  logic [N-1:0]  num_r;
  logic [W+1:0]  rem_r;
  logic [W-1:0]  root_r;
  logic [2*W-1:0] rad_r;

  logic [W:0]    mul_sum;
  logic [W:0]    div_sh;
  logic [W:0]    div_diff;
  logic          div_ge;
  logic [W+3:0]  sq_sh;
  logic [W+3:0]  sq_trial;
  logic [W+3:0]  sq_diff;
  logic          sq_ge;
  logic [2*W-1:0] prod;

  assign mul_sum  = {1'b0, hi_r} + (y_r[0] ? {1'b0, x_r} : '0);
  assign div_sh   = {rem_r[W-1:0], num_r[N-1]};
  assign div_ge   = div_sh >= {1'b0, x_r};
  assign div_diff = div_sh - {1'b0, x_r};
  assign sq_sh    = {rem_r, rad_r[2*W-1 -: 2]};
  assign sq_trial = (W+4)'({root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;
  assign prod     = {hi_r, lo_r};

  always_comb begin
    case (op_r)
      tmprof_pkg::ALU_MUL:  result = ((prod >> (W + F)) != '0) ? '1 : prod[F +: W];
      tmprof_pkg::ALU_DIV:  result = ((num_r >> W) != '0) ? '1 : num_r[W-1:0];
      default:              result = root_r;
    endcase
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= tmprof_pkg::ALU_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        rem_r  <= '0;
        root_r <= '0;
        hi_r   <= '0;
        lo_r   <= '0;
        x_r    <= (req.op == tmprof_pkg::ALU_DIV) ? opy : opx;
        y_r    <= opy;
        num_r  <= N'(opx) << F;
        rad_r  <= (2*W)'(opx) << F;
        cnt_r  <= (req.op == tmprof_pkg::ALU_DIV) ? CW'(N - 1) : CW'(W - 1);
      end else if (busy_r) begin
        case (op_r)
          tmprof_pkg::ALU_MUL: begin
            hi_r <= mul_sum[W:1];
            lo_r <= {mul_sum[0], lo_r[W-1:1]};
            y_r  <= y_r >> 1;
          end
          tmprof_pkg::ALU_DIV: begin
            rem_r <= (W+2)'(div_ge ? div_diff[W-1:0] : div_sh[W-1:0]);
            num_r <= {num_r[N-2:0], div_ge};
          end
          default: begin
            rem_r  <= sq_ge ? sq_diff[W+1:0] : sq_sh[W+1:0];
            root_r <= {root_r[W-2:0], sq_ge};
            rad_r  <= rad_r << 2;
          end
        endcase
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WL       = 32;
  localparam longint      FULL     = 64'hFFFF_FFFF;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [1:0]  CFG_SPARE = 2'd3;  // unmapped register index

  typedef struct {
    logic          cmd;
    logic [WL-1:0] t;
  } move_req_t;

  typedef struct {
    logic [WL-1:0] position;
    logic [WL-1:0] velocity;
    logic [WL-1:0] total_time;
    logic [1:0]    status;
  } kin_t;

  logic          clk, rst_n;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [WL-1:0] cfg_wdata;
  logic          in_valid, in_stall, in_command;
  logic [WL-1:0] in_sample_time;
  logic          out_valid, out_stall;
  logic [WL-1:0] out_position, out_velocity, out_total_time;
  logic [1:0]    out_status;

  trapezoid_motion_profile_core DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_command, .in_sample_time,
    .out_valid, .out_stall, .out_position, .out_velocity, .out_total_time, .out_status
  );

  // shadow registers and latched plan
  longint    reg_dist, reg_vel, reg_acc;
  longint    pl_ramp, pl_cruise_end, pl_total, pl_peak, pl_rdist, pl_dist, pl_acc;
  bit        pl_valid;

  move_req_t pending_moves[$];
  kin_t      expected_kin[$];
  int        n_issued, n_done, quiet_cycles;
  int        send_idle, recv_idle;
  bit        failed, in_took;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_w(longint x);
    return (x > FULL) ? FULL : x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    ua = a;
    ub = b;
    p = ua * ub;
    p = p >> 16;
    return (p > 128'(FULL)) ? FULL : longint'(p[63:0]);
  endfunction

  function automatic longint fx_div(longint a, longint d);
    if (d == 0) return FULL;
    return sat_w((a << 16) / d);
  endfunction

  function automatic longint fx_sqrt(longint x);
    longint v, r, c;
    v = x << 16;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return sat_w(r);
  endfunction

  function automatic longint ramp_dist(longint a, longint t);
    return fx_mul(fx_mul(a, t), t) >> 1;
  endfunction

  function automatic kin_t profile_at(move_req_t m);
    kin_t   k;
    longint d, v, a, tr, dr, t, t3, decel_base, dv, s;
    k = '{0, 0, 0, tmprof_pkg::STS_OK};
    if (m.cmd == tmprof_pkg::CMD_PLAN) begin
      d = (reg_dist == 0) ? 1 : reg_dist;
      v = reg_vel;
      a = reg_acc;
      if (v == 0 || a == 0) begin
        pl_valid = 1'b0;
        k.status = tmprof_pkg::STS_ZERO_LIMIT;
      end else begin
        tr = fx_div(v, a);
        dr = ramp_dist(a, tr);
        if (2 * dr >= d) begin
          tr = fx_sqrt(fx_div(d, a));
          pl_peak = fx_mul(a, tr);
          pl_total = sat_w(tr + tr);
          dr = ramp_dist(a, tr);
        end else begin
          pl_peak = v;
          pl_total = sat_w(sat_w(tr + tr) + fx_div(d - 2 * dr, v));
        end
        pl_ramp = tr;
        pl_rdist = dr;
        pl_cruise_end = (pl_total >= tr) ? pl_total - tr : 0;
        pl_dist = d;
        pl_acc = a;
        pl_valid = 1'b1;
        k.total_time = pl_total[WL-1:0];
      end
    end else if (!pl_valid) begin
      k.status = tmprof_pkg::STS_NO_PLAN;
    end else begin
      t = longint'(m.t);
      a = pl_acc;
      k.total_time = pl_total[WL-1:0];
      if (t <= pl_ramp) begin
        s = ramp_dist(a, t);
        dv = fx_mul(a, t);
      end else if (t <= pl_cruise_end) begin
        s = sat_w(pl_rdist + fx_mul(pl_peak, t - pl_ramp));
        dv = pl_peak;
      end else begin
        t3 = t - pl_cruise_end;
        decel_base = (pl_dist > pl_rdist) ? pl_dist - pl_rdist : 0;
        s = decel_base + fx_mul(pl_peak, t3) - ramp_dist(a, t3);
        if (s < 0) s = 0;
        dv = fx_mul(a, t3);
        dv = (pl_peak > dv) ? pl_peak - dv : 0;
      end
      if (s > pl_dist) s = pl_dist;
      k.position = s[WL-1:0];
      k.velocity = dv[WL-1:0];
    end
    return k;
  endfunction

  // driver: one payload held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_moves.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_command <= pending_moves[0].cmd;
          in_sample_time <= pending_moves[0].t;
          void'(pending_moves.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin
    kin_t got, exp_k;
    move_req_t m;
    bit took, done_now;
    took = rst_n && in_valid && !in_stall;
    done_now = rst_n && out_valid && !out_stall;
    in_took <= took;
    if (rst_n) begin
      quiet_cycles <= (took || done_now) ? 0 : quiet_cycles + 1;
      if (took) begin
        m.cmd = in_command;
        m.t = in_sample_time;
        expected_kin = {expected_kin, profile_at(m)};
      end
      if (done_now) begin
        n_done <= n_done + 1;
        got = '{out_position, out_velocity, out_total_time, out_status};
        if (expected_kin.size() == 0) begin
          $error("unexpected result transaction");
          failed = 1'b1;
        end else begin
          exp_k = expected_kin.pop_front();
          if (got.position !== exp_k.position) begin
            $error("position: expected %0h actual %0h", exp_k.position, got.position);
            failed = 1'b1;
          end
          if (got.velocity !== exp_k.velocity) begin
            $error("velocity: expected %0h actual %0h", exp_k.velocity, got.velocity);
            failed = 1'b1;
          end
          if (got.total_time !== exp_k.total_time) begin
            $error("total_time: expected %0h actual %0h", exp_k.total_time,
                   got.total_time);
            failed = 1'b1;
          end
          if (got.status !== exp_k.status) begin
            $error("status: expected %0d actual %0d", exp_k.status, got.status);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("trapezoid_motion_profile_core regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[WL-1:0];
    @(posedge clk);
    case (idx)
      tmprof_pkg::CFG_DIST:  reg_dist = val & FULL;
      tmprof_pkg::CFG_VEL:   reg_vel = val & FULL;
      tmprof_pkg::CFG_ACCEL: reg_acc = val & FULL;
      default: ;
    endcase
  endtask

  task automatic set_limits(longint d, longint v, longint a);
    write_reg(tmprof_pkg::CFG_DIST, d);
    write_reg(tmprof_pkg::CFG_VEL, v);
    write_reg(tmprof_pkg::CFG_ACCEL, a);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_move(logic cmd, longint t);
    move_req_t m;
    m.cmd = cmd;
    m.t = t[WL-1:0];
    pending_moves = {pending_moves, m};
    n_issued++;
  endtask

  task automatic drain;
    while (pending_moves.size() != 0 || n_done != n_issued) @(negedge clk);
  endtask

  // times on the phase boundaries of the latched plan
  task automatic queue_boundaries;
    queue_move(tmprof_pkg::CMD_SAMPLE, 0);
    queue_move(tmprof_pkg::CMD_SAMPLE, sat_w(pl_ramp));
    queue_move(tmprof_pkg::CMD_SAMPLE, sat_w(pl_ramp + 1));
    queue_move(tmprof_pkg::CMD_SAMPLE, sat_w(pl_cruise_end + 1));
    queue_move(tmprof_pkg::CMD_SAMPLE, sat_w(pl_total));
    queue_move(tmprof_pkg::CMD_SAMPLE, FULL);
  endtask

  function automatic longint pick_word(bit zero_ok);
    case ($urandom_range(9))
      0:       return zero_ok ? 0 : 1;
      1:       return FULL;
      2:       return longint'($urandom());
      3:       return longint'($urandom_range(255, 1));
      default: return longint'($urandom_range(32'h0100_0000, 32'h0000_1000));
    endcase
  endfunction

  task automatic random_phase(int n_samples);
    longint span;
    set_limits(pick_word(1), pick_word($urandom_range(15) == 0),
               pick_word($urandom_range(15) == 0));
    queue_move(tmprof_pkg::CMD_PLAN, longint'($urandom()));
    drain();
    span = sat_w(pl_total + pl_total / 4 + 1);
    for (int i = 0; i < n_samples; i++) begin
      case ($urandom_range(9))
        0:       queue_move(tmprof_pkg::CMD_SAMPLE, longint'($urandom()));
        1:       queue_move(tmprof_pkg::CMD_SAMPLE, sat_w(pl_ramp + $urandom_range(2)));
        2:       queue_move(tmprof_pkg::CMD_SAMPLE,
                            sat_w(pl_cruise_end + $urandom_range(2)));
        default: queue_move(tmprof_pkg::CMD_SAMPLE,
                            longint'($urandom_range(span[WL-1:0], 0)));
      endcase
    end
    if ($urandom_range(7) == 0) queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tmprof_pkg::CFG_DIST;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = tmprof_pkg::CMD_PLAN;
    in_sample_time = '0;
    out_stall = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    reg_dist = 64'h1_0000;
    reg_vel = 64'h1_0000;
    reg_acc = 64'h1_0000;
    pl_valid = 1'b0;
    {pl_ramp, pl_cruise_end, pl_total, pl_peak, pl_rdist, pl_dist, pl_acc} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sample before any plan, then plan with reset limits
    queue_move(tmprof_pkg::CMD_SAMPLE, 64'h1_0000);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
    queue_boundaries();
    drain();
    // zero velocity limit kills the plan
    set_limits(64'h1_0000, 0, 64'h1_0000);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    queue_move(tmprof_pkg::CMD_SAMPLE, 64'h8000);
    drain();
    set_limits(FULL, FULL, 0);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
    // zero distance floors at one LSB
    set_limits(0, 64'h1_0000, 64'h1_0000);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
    queue_boundaries();
    drain();
    // long cruise, then saturated ramp and total time
    set_limits(FULL, 64'h100, FULL);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
    queue_boundaries();
    drain();
    write_reg(CFG_SPARE, 64'h1234_5678);
    set_limits(FULL, FULL, 1);
    queue_move(tmprof_pkg::CMD_PLAN, 0);
    drain();
    queue_boundaries();
    drain();

    for (int seg = 0; seg < 3; seg++) begin
      send_idle = (seg == 0) ? 37 : (seg == 1) ? 75 : 0;
      recv_idle = (seg == 0) ? 75 : (seg == 1) ? 37 : 0;
      for (int p = 0; p < 30; p++) begin
        random_phase(18);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (!failed && expected_kin.size() == 0) begin
      $display("trapezoid_motion_profile_core regression: pass");
    end else begin
      $display("trapezoid_motion_profile_core regression: fail");
    end
    $finish;
  end

  initial begin
    n_issued = 0;
    n_done = 0;
    quiet_cycles = 0;
    failed = 1'b0;
    in_took = 1'b0;
  end

endmodule
`default_nettype wire

>>> trapezoid_motion_profile_core.f
rtl/core/tmprof_pkg.sv
rtl/core/tmprof_alu.sv
rtl/core/trapezoid_motion_profile_core.sv
tb/tb_top.sv
